>>> src/aes_pkg.sv
package aes_pkg;

   typedef struct packed {
      logic        command;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   // configuration register indexes
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [2:0] CSR_KEY_LENGTH = 3'd4;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [3:0] NR_128 = 4'd10;
   localparam logic [3:0] NR_256 = 4'd14;
   localparam int         RK_DEPTH = 15;

   localparam logic [7:0] FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] REV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] rcon(input logic [3:0] idx);
      logic [7:0] v;
      case (idx)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1b;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] subst_word(input logic [31:0] w);
      return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte b of the state (row b%4, column b/4)
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int b);
      return s[127 - 8*b -: 8];
   endfunction

   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                              input logic last);
      logic [127:0] t;
      logic [127:0] m;
      logic [7:0]   a0, a1, a2, a3;
      t = '0;
      m = '0;
      // substitute and rotate rows left
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = FWD_BOX[get_byte(s, 4*((c + r) % 4) + r)];
         end
      end
      // mix columns
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(t, 4*c);
         a1 = get_byte(t, 4*c + 1);
         a2 = get_byte(t, 4*c + 2);
         a3 = get_byte(t, 4*c + 3);
         m[127 - 32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
      end
      return (last ? t : m) ^ k;
   endfunction

   function automatic logic [7:0] inv_mul(input logic [7:0] x, input logic [1:0] sel);
      logic [7:0] x2, x4, x8, v;
      x2 = xtime(x);
      x4 = xtime(x2);
      x8 = xtime(x4);
      case (sel)
         2'd0:    v = x8 ^ x4 ^ x2;      // 14
         2'd1:    v = x8 ^ x2 ^ x;       // 11
         2'd2:    v = x8 ^ x4 ^ x;       // 13
         default: v = x8 ^ x;            // 9
      endcase
      return v;
   endfunction

   function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                              input logic last);
      logic [127:0] t;
      logic [127:0] m;
      logic [7:0]   a0, a1, a2, a3;
      t = '0;
      m = '0;
      // rotate rows right, substitute, add key
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = REV_BOX[get_byte(s, 4*((c + 4 - r) % 4) + r)];
         end
      end
      t = t ^ k;
      // inverse mix columns
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(t, 4*c);
         a1 = get_byte(t, 4*c + 1);
         a2 = get_byte(t, 4*c + 2);
         a3 = get_byte(t, 4*c + 3);
         m[127 - 32*c -: 32] = {
            inv_mul(a0, 2'd0) ^ inv_mul(a1, 2'd1) ^ inv_mul(a2, 2'd2) ^ inv_mul(a3, 2'd3),
            inv_mul(a0, 2'd3) ^ inv_mul(a1, 2'd0) ^ inv_mul(a2, 2'd1) ^ inv_mul(a3, 2'd2),
            inv_mul(a0, 2'd2) ^ inv_mul(a1, 2'd3) ^ inv_mul(a2, 2'd0) ^ inv_mul(a3, 2'd1),
            inv_mul(a0, 2'd1) ^ inv_mul(a1, 2'd2) ^ inv_mul(a2, 2'd3) ^ inv_mul(a3, 2'd0)};
      end
      return last ? t : m;
   endfunction

endpackage

>>> src/aes_block_cipher_128_256_top.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_data (command, block_high, block_low)
// rsp       out        rsp_valid / rsp_stall   rsp_data (result_high, result_low)
// csr       in         csr_we                  csr_index, csr_wdata
//
// A block goes from accept to result valid through the expansion of Nr + 1 round keys,
// one key fetch, one whitening and Nr rounds (Nr is 10 for AES-128, 14 for AES-256).
// The next block is accepted in the cycle after the result is taken.
// The round keys are expanded into a 15-entry key memory, one round key per cycle,
// then one shared round unit runs one round per cycle off that memory.
// Reset is synchronous and clears the sequencer, the result valid and the key registers.
// req_stall stays high while a block is in work or its result waits on rsp_stall.
module aes_block_cipher_128_256_top
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_WHITEN = 3'd3;
   localparam logic [2:0] ST_ROUND  = 3'd4;

   logic [63:0]  key0_ff, key1_ff, key2_ff, key3_ff;
   logic         key_len_ff;
   logic [2:0]   state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         cmd_ff, cmd_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] win_a_ff, win_a_in, win_b_ff, win_b_in;
   logic [127:0] rk_mem_ff [RK_DEPTH];
   logic [127:0] rk_q_ff;
   logic [3:0]   rd_addr;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;
   logic [3:0]   nr;
   logic         req_fire;
   logic [31:0]  last_w, t_w, n0, n1, n2, n3;
   logic         use_rot;
   logic [3:0]   rc_idx;
   logic [127:0] gen_key;
   logic         last_rnd;

   assign nr       = key_len_ff ? NR_256 : NR_128;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_fire = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign last_rnd = (cnt_ff == nr);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff    <= '0;
         key1_ff    <= '0;
         key2_ff    <= '0;
         key3_ff    <= '0;
         key_len_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_WORD_0: key0_ff    <= csr_wdata;
            CSR_KEY_WORD_1: key1_ff    <= csr_wdata;
            CSR_KEY_WORD_2: key2_ff    <= csr_wdata;
            CSR_KEY_WORD_3: key3_ff    <= csr_wdata;
            CSR_KEY_LENGTH: key_len_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next round key from the expansion window
   always_comb begin
      last_w  = key_len_ff ? win_b_ff[31:0] : win_a_ff[31:0];
      use_rot = !key_len_ff || !cnt_ff[0];
      rc_idx  = key_len_ff ? ((cnt_ff + 4'd2) >> 1) : (cnt_ff + 4'd1);
      t_w     = use_rot ? (subst_word({last_w[23:0], last_w[31:24]}) ^ {rcon(rc_idx), 24'h0})
                        : subst_word(last_w);
      n0      = win_a_ff[127:96] ^ t_w;
      n1      = win_a_ff[95:64]  ^ n0;
      n2      = win_a_ff[63:32]  ^ n1;
      n3      = win_a_ff[31:0]   ^ n2;
      gen_key = {n0, n1, n2, n3};
   end

   // key memory read address
   always_comb begin
      rd_addr = 4'd0;
      case (state_ff)
         ST_FETCH:  rd_addr = (cmd_ff == CMD_DECRYPT) ? nr : 4'd0;
         ST_WHITEN: rd_addr = (cmd_ff == CMD_DECRYPT) ? (nr - 4'd1) : 4'd1;
         ST_ROUND: begin
            if (!last_rnd) begin
               rd_addr = (cmd_ff == CMD_DECRYPT) ? (nr - cnt_ff - 4'd1) : (cnt_ff + 4'd1);
            end
         end
         default: rd_addr = 4'd0;
      endcase
   end

   // key memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXPAND) begin
         rk_mem_ff[cnt_ff] <= win_a_ff;
      end
      rk_q_ff <= rk_mem_ff[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      st_in        = st_ff;
      win_a_in     = win_a_ff;
      win_b_in     = win_b_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_data.command;
               st_in    = {req_data.block_high, req_data.block_low};
               win_a_in = {key0_ff, key1_ff};
               win_b_in = {key2_ff, key3_ff};
               cnt_in   = 4'd0;
               state_in = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            if (key_len_ff) begin
               win_a_in = win_b_ff;
               win_b_in = gen_key;
            end else begin
               win_a_in = gen_key;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == nr) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_WHITEN;
         ST_WHITEN: begin
            st_in    = st_ff ^ rk_q_ff;
            cnt_in   = 4'd1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            st_in  = (cmd_ff == CMD_DECRYPT) ? dec_round(st_ff, rk_q_ff, last_rnd)
                                             : enc_round(st_ff, rk_q_ff, last_rnd);
            cnt_in = cnt_ff + 4'd1;
            if (last_rnd) begin
               rsp_data_in  = st_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      st_ff       <= st_in;
      win_a_ff    <= win_a_in;
      win_b_ff    <= win_b_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> src/aes_chk.sv
module aes_chk
   import aes_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // block busy right after a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("not busy after accept");

   // no new request while a result waits
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   // result shows for one transaction only
   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result repeated");

endmodule

bind aes_block_cipher_128_256_top aes_chk u_aes_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
